### src/aabb_overlap_pair_finder_macros.svh
// Assertion macros for the overlap pair finder
`ifndef AABB_OVERLAP_PAIR_FINDER_MACROS_SVH
`define AABB_OVERLAP_PAIR_FINDER_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define AOPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every rising clock edge outside reset
`define AOPF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/aopf_pkg.sv
// ---------------------------------------------------------------------------
// aopf_pkg
// Shared constants and types for the overlap pair finder.
// ---------------------------------------------------------------------------
package aopf_pkg;

    localparam int MAX_BOXES_DEF   = 64;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int ID_W            = 16;
    localparam int IN_W            = 32;
    localparam int MASK_W          = 64;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SWEEP,
        ST_EMIT
    } aopf_state_t;

    // Control from the sequencer to the cell row
    typedef struct packed {
        logic load;      // store incoming box into the next free cell
        logic clear;     // drop all cells at end of run
        logic rotate;    // shift the probe token one cell along
        logic probe_ld;  // load probe ring from the stored boxes
    } aopf_ctrl_t;

endpackage

### src/aopf_cell.sv
// ---------------------------------------------------------------------------
// aopf_cell
// One slot of the box row: holds a box, compares it with the probe box
// passing by and hands the probe on to its neighbour.
// ---------------------------------------------------------------------------
module aopf_cell #(
    parameter int CW = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  aopf_pkg::aopf_ctrl_t      ctrl,
    input  logic                      sel,       // this cell takes the load
    input  logic [aopf_pkg::ID_W-1:0] in_id,
    input  logic [6*CW-1:0]           in_box,
    input  logic [6*CW-1:0]           probe_in,  // from previous cell
    input  logic                      pvalid_in,
    output logic [6*CW-1:0]           probe_out,
    output logic                      pvalid_out,
    output logic [aopf_pkg::ID_W-1:0] id_out,
    output logic                      hit        // probe overlaps stored box
);
    import aopf_pkg::*;

    logic [ID_W-1:0]  id_reg;
    logic [6*CW-1:0]  box_reg;
    logic             valid_reg;
    logic [6*CW-1:0]  probe_reg;
    logic             pvalid_reg;

    // Box field order: min x, min y, min z, max x, max y, max z (low first)
    function automatic logic signed [CW-1:0] fld(input logic [6*CW-1:0] b, input int k);
        fld = b[k*CW +: CW];
    endfunction

    // Stored box
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.load && sel)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load && sel)
        begin
            id_reg  <= in_id;
            box_reg <= in_box;
        end
    end

    // Probe ring stage; the box loaded with the probe load goes straight in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
        end
        else if (ctrl.probe_ld)
        begin
            pvalid_reg <= valid_reg || (ctrl.load && sel);
        end
        else if (ctrl.rotate)
        begin
            pvalid_reg <= pvalid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.probe_ld)
        begin
            probe_reg <= (ctrl.load && sel) ? in_box : box_reg;
        end
        else if (ctrl.rotate)
        begin
            probe_reg <= probe_in;
        end
    end

    // Overlap test: x inclusive, y and z strict
    always_comb
    begin
        hit = valid_reg && pvalid_reg
            && (fld(box_reg, 0) <= fld(probe_reg, 3)) && (fld(probe_reg, 0) <= fld(box_reg, 3))
            && (fld(box_reg, 1) <  fld(probe_reg, 4)) && (fld(probe_reg, 1) <  fld(box_reg, 4))
            && (fld(box_reg, 2) <  fld(probe_reg, 5)) && (fld(probe_reg, 2) <  fld(box_reg, 5));
    end

    assign probe_out  = probe_reg;
    assign pvalid_out = pvalid_reg;
    assign id_out     = id_reg;

endmodule

### src/aabb_overlap_pair_finder.sv
// ---------------------------------------------------------------------------
// aabb_overlap_pair_finder
// Broad-phase box overlap finder built from a row of compare cells.
// ---------------------------------------------------------------------------
// Boxes load one per cycle while the block is in its load state into a row of
// MAX_BOXES cells. On the box marked last the block stops taking input and sweeps:
// every stored box is copied into a probe ring that rotates one cell per cycle,
// so as the ring turns each cell meets every other box, and cell i builds its
// overlap mask. Results then leave one per cycle, when the output is not stalled,
// in load order through an output register. The sweep length is set by the ring
// length, not by the number of boxes in the run.
module aabb_overlap_pair_finder #(
    parameter int MAX_BOXES   = aopf_pkg::MAX_BOXES_DEF,
    parameter int COORD_WIDTH = aopf_pkg::COORD_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [aopf_pkg::ID_W-1:0]    body_id,
    input  logic signed [aopf_pkg::IN_W-1:0] min_x,
    input  logic signed [aopf_pkg::IN_W-1:0] min_y,
    input  logic signed [aopf_pkg::IN_W-1:0] min_z,
    input  logic signed [aopf_pkg::IN_W-1:0] max_x,
    input  logic signed [aopf_pkg::IN_W-1:0] max_y,
    input  logic signed [aopf_pkg::IN_W-1:0] max_z,
    input  logic                         last_box,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [aopf_pkg::ID_W-1:0]    owner_id,
    output logic [aopf_pkg::MASK_W-1:0]  overlap_mask,
    output logic                         dropped_flag,
    output logic                         last_result
);
    import aopf_pkg::*;
    `include "aabb_overlap_pair_finder_macros.svh"

    localparam int CW  = COORD_WIDTH;
    localparam int IXW = $clog2(MAX_BOXES);
    localparam int CNW = $clog2(MAX_BOXES + 1);

    aopf_state_t state_reg, state_next;
    logic [CNW-1:0] count_reg, count_next;
    logic [CNW-1:0] step_reg, step_next;
    logic           ovf_reg, ovf_next;
    logic [MASK_W-1:0] mask_reg [MAX_BOXES];
    aopf_ctrl_t     ctrl;

    logic [6*CW-1:0] in_box;
    logic [6*CW-1:0] probe [MAX_BOXES];
    logic            pvalid [MAX_BOXES];
    logic [ID_W-1:0] ids [MAX_BOXES];
    logic            hits [MAX_BOXES];

    logic [ID_W-1:0]   oid_reg;
    logic [MASK_W-1:0] omask_reg;
    logic              odrop_reg, olast_reg, ovalid_reg;
    logic              in_fire, out_free, emit_fire;
    logic [IXW-1:0]    emit_ix;

    // Sign-extend, then saturate to the coordinate width
    function automatic logic [CW-1:0] sat(input logic signed [IN_W-1:0] v);
        logic signed [IN_W+CW-1:0] w;
        logic signed [IN_W+CW-1:0] hi;
        logic signed [IN_W+CW-1:0] lo;
        w  = (IN_W+CW)'(v);
        hi = (IN_W+CW)'((64'sd1 <<< (CW - 1)) - 64'sd1);
        lo = -hi - (IN_W+CW)'(1);
        if (w > hi)
            sat = hi[CW-1:0];
        else if (w < lo)
            sat = lo[CW-1:0];
        else
            sat = w[CW-1:0];
    endfunction

    assign in_box = {sat(max_z), sat(max_y), sat(max_x), sat(min_z), sat(min_y), sat(min_x)};

    assign in_ready  = (state_reg == ST_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !ovalid_reg || out_ready;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;
    assign emit_ix   = step_reg[IXW-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (in_fire && last_box)
                    state_next = (count_next == '0) ? ST_LOAD : ST_SWEEP;
            ST_SWEEP:
                if (step_reg == CNW'(MAX_BOXES - 1))
                    state_next = ST_EMIT;
            ST_EMIT:
                if (emit_fire && (step_reg == count_reg - CNW'(1)))
                    state_next = ST_LOAD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // Control outputs and counters
    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        step_next  = step_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (count_reg < CNW'(MAX_BOXES))
                    begin
                        ctrl.load  = 1'b1;
                        count_next = count_reg + CNW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_box)
                    begin
                        ctrl.probe_ld = 1'b1;
                        step_next     = '0;
                        if (count_next == '0)
                            ovf_next = 1'b0;
                    end
                end
            end
            ST_SWEEP:
            begin
                ctrl.rotate = 1'b1;
                step_next   = (step_reg == CNW'(MAX_BOXES - 1)) ? '0 : step_reg + CNW'(1);
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    step_next = step_reg + CNW'(1);
                    if (step_reg == count_reg - CNW'(1))
                    begin
                        ctrl.clear = 1'b1;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        step_next  = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            step_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Row of cells; probe ring runs from cell i to cell i+1
    for (genvar i = 0; i < MAX_BOXES; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? MAX_BOXES - 1 : i - 1;
        logic [IXW-1:0] src_ix;

        aopf_cell #(.CW(CW)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .sel        (count_reg == CNW'(i)),
            .in_id      (body_id),
            .in_box     (in_box),
            .probe_in   (probe[PREV]),
            .pvalid_in  (pvalid[PREV]),
            .probe_out  (probe[i]),
            .pvalid_out (pvalid[i]),
            .id_out     (ids[i]),
            .hit        (hits[i])
        );

        // Probe at cell i after s rotations came from box (i - s) mod N
        always_comb
        begin
            if (int'(step_reg) <= i)
                src_ix = IXW'(i - int'(step_reg));
            else
                src_ix = IXW'(i + MAX_BOXES - int'(step_reg));
        end

        // Mask accumulation; step 0 is the cell seeing itself, skipped
        always_ff @(posedge clk)
        begin
            if (ctrl.probe_ld)
                mask_reg[i] <= '0;
            else if (state_reg == ST_SWEEP && step_reg != '0 && hits[i])
                mask_reg[i][src_ix] <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (emit_fire)
            ovalid_reg <= 1'b1;
        else if (out_ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            oid_reg   <= ids[emit_ix];
            omask_reg <= mask_reg[emit_ix];
            odrop_reg <= ovf_reg;
            olast_reg <= (step_reg == count_reg - CNW'(1));
        end
    end

    assign out_valid    = ovalid_reg;
    assign owner_id     = oid_reg;
    assign overlap_mask = omask_reg;
    assign dropped_flag = odrop_reg;
    assign last_result  = olast_reg;

    `AOPF_ASSERT(a_count_range, count_reg <= CNW'(MAX_BOXES), "box count above capacity")
    `AOPF_ASSERT_IMP(a_no_load_busy, state_reg != ST_LOAD, !in_ready, "input taken while busy")
    `AOPF_ASSERT_IMP(a_emit_nonempty, state_reg == ST_EMIT, count_reg != '0, "emitting empty run")

endmodule
